>>> rtl/binned_sum_count_accumulator_defines.svh
// Assertion macros used by the checker file of the binned sum/count accumulator.
`ifndef BINNED_SUM_COUNT_ACCUMULATOR_DEFINES_SVH
`define BINNED_SUM_COUNT_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BSCA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bsca_pkg.sv
// Shared types and constants for the binned sum/count accumulator.
package bsca_pkg;

    // Field widths fixed by the word formats.
    localparam int BAND_W  = 4;
    localparam int VALUE_W = 31;
    localparam int DATA_W  = 32;

    // Request codes.
    localparam logic REQ_ACCUM = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // One bin: running sum and running count.
    typedef struct packed {
        logic [DATA_W-1:0] sum;
        logic [DATA_W-1:0] count;
    } t_bin_entry;

    // Table controller states.
    typedef enum logic [0:0] {
        TBL_CLEAR,
        TBL_RUN
    } t_tbl_state;

endpackage

>>> rtl/bsca_if.sv
// Valid/ready channel interfaces for the input rows and the result words.
interface bsca_in_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [bsca_pkg::BAND_W-1:0] band_a;
    logic [bsca_pkg::BAND_W-1:0] band_b;
    logic [bsca_pkg::BAND_W-1:0] band_c;
    logic [bsca_pkg::VALUE_W-1:0] sample_value;
    logic                        last_row;

    modport source (output valid, req_type, band_a, band_b, band_c, sample_value, last_row,
                    input ready);
    modport sink (input valid, req_type, band_a, band_b, band_c, sample_value, last_row,
                  output ready);
endinterface

interface bsca_out_if;
    logic                        valid;
    logic                        ready;
    logic [bsca_pkg::DATA_W-1:0] bin_sum;
    logic [bsca_pkg::DATA_W-1:0] bin_count;
    logic                        overflow;
    logic                        batch_done;

    modport source (output valid, bin_sum, bin_count, overflow, batch_done, input ready);
    modport sink (input valid, bin_sum, bin_count, overflow, batch_done, output ready);
endinterface

>>> rtl/binned_sum_count_accumulator.sv
// Top level of the binned sum/count accumulator: a 3-D histogram of sums and counts.
//
// Input rows arrive on i_in (valid/ready); each accepted word names a bin by
// band_a, band_b and band_c and either accumulates sample_value into it or
// reads it. Exactly one result word leaves on o_out for every input word,
// in order, carrying the bin's sum and count after the request, an overflow
// flag (the entry is left as it was) and batch_done echoing last_row.
// A band index of BAND_BINS or more gives a zero result and touches nothing.
// A word accepted on i_in passes through the update stage, where the
// registered table read is combined, and then through the output register.
// Throughput: one word per cycle while no stall holds the output register, set by the single
// read-modify-write pass over the memory; back-to-back words to the same
// bin are served by forwarding the last write.
// Reset: both tables are swept to zero, one entry per cycle, so i_in.ready
// stays low until all BAND_BINS^3 entries (4096 at the default) are cleared.
// Stall: the result sits in the output register while o_out.ready is low;
// one more word can be accepted and is held in the update stage behind it.
module binned_sum_count_accumulator #(
    parameter int BAND_BINS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bsca_in_if.sink           i_in,
    bsca_out_if.source        o_out
);
    localparam int BinCount = BAND_BINS * BAND_BINS * BAND_BINS;
    localparam int AW       = $clog2(BinCount);

    logic                 w_busy;
    logic                 w_accept;
    logic                 w_in_range;
    logic [31:0]          w_addr_full;
    logic [AW-1:0]        w_addr;
    bsca_pkg::t_bin_entry w_rd_entry;

    // Update stage.
    logic                         r_s1_valid;
    logic                         r_s1_req;
    logic                         r_s1_in_range;
    logic [bsca_pkg::VALUE_W-1:0] r_s1_value;
    logic                         r_s1_last;
    logic [AW-1:0]                r_s1_addr;
    logic                         w_s1_adv;

    logic [bsca_pkg::DATA_W:0]    w_sum_ext;
    logic                         w_ovf;
    logic                         w_wr_en;
    bsca_pkg::t_bin_entry         w_wr_entry;
    bsca_pkg::t_bin_entry         n_out_entry;
    logic                         n_out_ovf;

    // Output register.
    logic                         r_out_valid;
    bsca_pkg::t_bin_entry         r_out_entry;
    logic                         r_out_ovf;
    logic                         r_out_last;

    // Bin address and range check for the incoming word.
    assign w_in_range = (32'(i_in.band_a) < 32'(BAND_BINS)) &&
                        (32'(i_in.band_b) < 32'(BAND_BINS)) &&
                        (32'(i_in.band_c) < 32'(BAND_BINS));
    assign w_addr_full = (32'(i_in.band_a) * 32'(BAND_BINS) + 32'(i_in.band_b))
                         * 32'(BAND_BINS) + 32'(i_in.band_c);
    assign w_addr = w_addr_full[AW-1:0];

    // Handshake: the update stage moves on when the output register frees up.
    assign w_s1_adv   = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !w_busy && (!r_s1_valid || w_s1_adv);
    assign w_accept   = i_in.valid && i_in.ready;

    bsca_table #(
        .DEPTH (BinCount)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_accept),
        .i_rd_addr  (w_addr),
        .o_rd_entry (w_rd_entry),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (r_s1_addr),
        .i_wr_entry (w_wr_entry),
        .o_busy     (w_busy)
    );

    // Update stage valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Update stage payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_req      <= i_in.req_type;
            r_s1_in_range <= w_in_range;
            r_s1_value    <= i_in.sample_value;
            r_s1_last     <= i_in.last_row;
            r_s1_addr     <= w_addr;
        end
    end

    // Accumulate with wrap detection on both the sum and the count.
    assign w_sum_ext = {1'b0, w_rd_entry.sum} + (bsca_pkg::DATA_W + 1)'(r_s1_value);
    assign w_ovf     = w_sum_ext[bsca_pkg::DATA_W] || (&w_rd_entry.count);
    assign w_wr_entry.sum   = w_sum_ext[bsca_pkg::DATA_W-1:0];
    assign w_wr_entry.count = w_rd_entry.count + bsca_pkg::DATA_W'(1);
    assign w_wr_en = w_s1_adv && r_s1_in_range && (r_s1_req == bsca_pkg::REQ_ACCUM) && !w_ovf;

    // Result selection.
    always_comb begin
        n_out_entry = '0;
        n_out_ovf   = 1'b0;
        if (r_s1_in_range) begin
            case (r_s1_req)
                bsca_pkg::REQ_ACCUM: begin
                    n_out_entry = w_ovf ? w_rd_entry : w_wr_entry;
                    n_out_ovf   = w_ovf;
                end
                default: begin
                    n_out_entry = w_rd_entry;
                end
            endcase
        end
    end

    // Output register valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_entry <= n_out_entry;
            r_out_ovf   <= n_out_ovf;
            r_out_last  <= r_s1_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.bin_sum    = r_out_entry.sum;
    assign o_out.bin_count  = r_out_entry.count;
    assign o_out.overflow   = r_out_ovf;
    assign o_out.batch_done = r_out_last;

endmodule

>>> rtl/bsca_table.sv
// Sum and count tables with a clearing sweep after reset and write-to-read forwarding.
module bsca_table #(
    parameter int DEPTH = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]            i_rd_addr,
    output bsca_pkg::t_bin_entry                o_rd_entry,
    input  logic                                i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]            i_wr_addr,
    input  bsca_pkg::t_bin_entry                i_wr_entry,
    output logic                                o_busy
);
    localparam int AW = $clog2(DEPTH);

    bsca_pkg::t_tbl_state r_state;
    bsca_pkg::t_tbl_state n_state;
    logic [AW-1:0]        r_clr_addr;
    logic [AW-1:0]        n_clr_addr;
    logic                 w_clearing;

    logic [bsca_pkg::DATA_W-1:0] r_sum_mem [DEPTH];
    logic [bsca_pkg::DATA_W-1:0] r_cnt_mem [DEPTH];
    logic                        w_we;
    logic [AW-1:0]               w_wa;
    bsca_pkg::t_bin_entry        w_wd;

    logic [AW-1:0]        r_rd_addr;
    bsca_pkg::t_bin_entry r_rd_data;
    logic                 r_lw_valid;
    logic [AW-1:0]        r_lw_addr;
    bsca_pkg::t_bin_entry r_lw_entry;

    // State register and sweep address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bsca_pkg::TBL_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    // The sweep zeroes one entry per cycle, then the tables go into service.
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        w_clearing = 1'b0;
        unique case (r_state)
            bsca_pkg::TBL_CLEAR: begin
                w_clearing = 1'b1;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state    = bsca_pkg::TBL_RUN;
                    n_clr_addr = '0;
                end
            end
            bsca_pkg::TBL_RUN: begin
                w_clearing = 1'b0;
            end
            default: begin
                n_state = bsca_pkg::TBL_CLEAR;
            end
        endcase
    end

    assign o_busy = w_clearing;

    // One write port shared by the sweep and the update path.
    assign w_we = w_clearing || i_wr_en;
    assign w_wa = w_clearing ? r_clr_addr : i_wr_addr;
    assign w_wd = w_clearing ? '0 : i_wr_entry;

    // Memories: read data is registered and returns the old value on a same-edge write.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_sum_mem[w_wa] <= w_wd.sum;
            r_cnt_mem[w_wa] <= w_wd.count;
        end
        if (i_rd_en) begin
            r_rd_data.sum   <= r_sum_mem[i_rd_addr];
            r_rd_data.count <= r_cnt_mem[i_rd_addr];
            r_rd_addr       <= i_rd_addr;
        end
    end

    // Last write is kept so a read that raced it sees the new value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw_valid <= 1'b0;
        end else if (w_clearing) begin
            r_lw_valid <= 1'b0;
        end else if (i_wr_en) begin
            r_lw_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_lw_addr  <= i_wr_addr;
            r_lw_entry <= i_wr_entry;
        end
    end

    // Forwarding mux on the read data.
    assign o_rd_entry = (r_lw_valid && (r_lw_addr == r_rd_addr)) ? r_lw_entry : r_rd_data;

endmodule

>>> rtl/bsca_checker.sv
// Port-level checker for the binned sum/count accumulator, with its bind statement.
`include "binned_sum_count_accumulator_defines.svh"

module bsca_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_bin_sum,
    input logic [31:0] i_out_bin_count,
    input logic        i_out_overflow
);

    // The clearing sweep keeps the input closed right after reset.
    `BSCA_ASSERT_NOW(a_closed_after_reset, i_clk, i_rst_n,
                     !$past(i_rst_n), !i_in_ready, "input open during clearing sweep")

    // A result word holds until it is taken.
    `BSCA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
                      i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")

    // A rising result valid must match an accepted word that went through the update stage.
    `BSCA_ASSERT_NOW(a_out_from_input, i_clk, i_rst_n,
                     $rose(i_out_valid), $past(i_in_valid && i_in_ready, 2),
                     "result without a matching input word")

    // Overflow needs a sum above half range or a saturated count.
    `BSCA_ASSERT_NOW(a_ovf_plausible, i_clk, i_rst_n,
                     i_out_valid && i_out_overflow, i_out_bin_sum[31] || (&i_out_bin_count),
                     "overflow flagged on a small bin")

endmodule

bind binned_sum_count_accumulator bsca_port_checker u_bsca_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_bin_sum   (o_out.bin_sum),
    .i_out_bin_count (o_out.bin_count),
    .i_out_overflow  (o_out.overflow)
);
